// ===== hdl/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
// Depends on nothing; every other file imports it.
package tcce_pkg;

    // Fixed field widths of the two channels and the attribute register.
    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int ADDR_IN_W = 11;
    localparam int WORD_W    = 16;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int POS_OUT_W = 11;
    localparam int ATTR_W    = 8;

    // Command codes carried in the op field.
    localparam logic [OP_W-1:0] OP_PUT       = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    // Character codes and the attribute value after reset.
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    // Input beat.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    char_code;
        logic [ADDR_IN_W-1:0] cell_addr;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [WORD_W-1:0]    read_word;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [POS_OUT_W-1:0] cursor_pos;
        logic [ROW_OUT_W-1:0] start_row;
    } res_t;

    // Classified command as it travels from the front end to the executor.
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_MARK,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [CHAR_W-1:0]    char_code;
        logic [ADDR_IN_W-1:0] cell_addr;
        logic                 read_hit;
    } cmd_t;

endpackage

// ===== hdl/tcce_front.sv =====
// Front end: accepts input beats, classifies them into commands and holds one.
// Depends on tcce_pkg.
module tcce_front import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  init_done,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_data,
    output logic  cmd_valid,
    input  logic  cmd_ready,
    output cmd_t  cmd_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic front_valid_reg, front_valid_next;
    cmd_t front_cmd_reg, front_cmd_next;
    cmd_t decoded;

    // Decode the op field; a new-line character becomes its own command.
    always_comb begin
        decoded.char_code = s_data.char_code;
        decoded.cell_addr = s_data.cell_addr;
        decoded.read_hit  = (int'(s_data.cell_addr) < CELL_COUNT);
        unique case (s_data.op)
            OP_PUT: begin
                decoded.kind = (s_data.char_code == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
            end
            OP_BACKSPACE: decoded.kind = CMD_BACKSPACE;
            OP_CLEAR:     decoded.kind = CMD_CLEAR;
            OP_MARK:      decoded.kind = CMD_MARK;
            OP_READ:      decoded.kind = CMD_READ;
            default:      decoded.kind = CMD_NOP;
        endcase
    end

    // The stage frees up whenever the queue takes its beat.
    assign s_ready = init_done && (!front_valid_reg || cmd_ready);

    always_comb begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (s_valid && s_ready) begin
            front_valid_next = 1'b1;
            front_cmd_next   = decoded;
        end else if (cmd_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_cmd_reg <= front_cmd_next;
    end

    assign cmd_valid = front_valid_reg;
    assign cmd_data  = front_cmd_reg;

endmodule

// ===== hdl/tcce_fifo.sv =====
// Two-entry command queue between the front end and the executor.
// Depends on tcce_pkg.
module tcce_fifo import tcce_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_data
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/tcce_exec.sv =====
// Executor: owns the screen store, cursor, guard position and result register.
// Depends on tcce_pkg.
module tcce_exec import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd_data,
    output logic              init_done,
    output logic              m_valid,
    input  logic              m_ready,
    output res_t              m_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_SWEEP,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  gcol_reg, gcol_next;
    logic [ROW_W-1:0]  grow_reg, grow_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [CNT_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;
    logic              cp_valid_reg, cp_valid_next;
    logic              read_hit_reg, read_hit_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;

    // Screen store: one write port, one registered read port.
    logic [CHAR_W-1:0] screen_mem [CELL_COUNT];
    logic [CHAR_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;

    logic [ADDR_W-1:0] cur_idx;
    logic              line_feed;
    logic              at_guard;

    assign cur_idx  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign at_guard = (col_reg == gcol_reg) && (row_reg == grow_reg);

    assign init_done = (state_reg != S_INIT);
    assign cmd_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Next-state and datapath control.
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        gcol_next      = gcol_reg;
        grow_next      = grow_reg;
        attr_next      = cfg_wr_en ? cfg_wr_data : attr_reg;
        sweep_cnt_next = sweep_cnt_reg;
        src_next       = src_reg;
        cp_dst_next    = cp_dst_reg;
        cp_valid_next  = cp_valid_reg;
        read_hit_next  = read_hit_reg;
        m_valid_next   = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_idx;
        mem_wdata      = BLANK_CHAR;
        mem_raddr      = ADDR_W'(cmd_data.cell_addr);
        line_feed      = 1'b0;

        unique case (state_reg)
            // Blank the whole store after reset, one cell per cycle.
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_cnt_reg[ADDR_W-1:0];
                if (sweep_cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + CNT_W'(1);
                end
            end

            // Take one command and carry out the part of it that this state does.
            S_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    state_next    = S_EMIT;
                    read_hit_next = 1'b0;
                    case (cmd_data.kind)
                        CMD_PUT: begin
                            mem_we    = 1'b1;
                            mem_wdata = cmd_data.char_code;
                            if (col_reg == COL_W'(COLUMNS - 1)) begin
                                line_feed = 1'b1;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        CMD_NEWLINE: line_feed = 1'b1;
                        CMD_BACKSPACE: begin
                            if (!at_guard) begin
                                mem_we = 1'b1;
                                if (col_reg != '0) begin
                                    col_next  = col_reg - COL_W'(1);
                                    mem_waddr = cur_idx - ADDR_W'(1);
                                end else if (row_reg > grow_reg) begin
                                    row_next  = row_reg - ROW_W'(1);
                                    col_next  = COL_W'(COLUMNS - 1);
                                    mem_waddr = cur_idx - ADDR_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            col_next       = '0;
                            row_next       = '0;
                            sweep_cnt_next = '0;
                            state_next     = S_SWEEP;
                        end
                        CMD_MARK: begin
                            gcol_next = col_reg;
                            grow_next = row_reg;
                        end
                        CMD_READ: read_hit_next = cmd_data.read_hit;
                        default: ;
                    endcase

                    // New line: move down, or scroll from the bottom row.
                    if (line_feed) begin
                        col_next = '0;
                        if (row_reg != ROW_W'(ROWS - 1)) begin
                            row_next = row_reg + ROW_W'(1);
                        end else begin
                            if (grow_reg != '0) begin
                                grow_next = grow_reg - ROW_W'(1);
                            end
                            src_next      = CNT_W'(COLUMNS);
                            cp_valid_next = 1'b0;
                            state_next    = S_SCROLL;
                        end
                    end
                end
            end

            // Copy each cell up one row: read one row ahead, write it in the next cycle.
            S_SCROLL: begin
                if (cp_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_dst_reg;
                    mem_wdata = rdata_reg;
                end
                if (src_reg != CNT_W'(CELL_COUNT)) begin
                    mem_raddr     = src_reg[ADDR_W-1:0];
                    src_next      = src_reg + CNT_W'(1);
                    cp_valid_next = 1'b1;
                    cp_dst_next   = ADDR_W'(src_reg - CNT_W'(COLUMNS));
                end else begin
                    cp_valid_next  = 1'b0;
                    sweep_cnt_next = CNT_W'(LAST_ROW);
                    state_next     = S_SWEEP;
                end
            end

            // Blank cells up to the end of the store, then report.
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_cnt_reg[ADDR_W-1:0];
                if (sweep_cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    state_next = S_EMIT;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + CNT_W'(1);
                end
            end

            // Load the result register; it was free when the command was taken.
            S_EMIT: begin
                m_valid_next           = 1'b1;
                m_data_next.read_word  = read_hit_reg ? {attr_reg, rdata_reg} : '0;
                m_data_next.cursor_col = COL_OUT_W'(col_reg);
                m_data_next.cursor_row = ROW_OUT_W'(row_reg);
                m_data_next.cursor_pos = POS_OUT_W'(cur_idx);
                m_data_next.start_row  = ROW_OUT_W'(grow_reg);
                state_next             = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            gcol_reg      <= '0;
            grow_reg      <= '0;
            attr_reg      <= ATTR_RESET;
            sweep_cnt_reg <= '0;
            cp_valid_reg  <= 1'b0;
            read_hit_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            gcol_reg      <= gcol_next;
            grow_reg      <= grow_next;
            attr_reg      <= attr_next;
            sweep_cnt_reg <= sweep_cnt_next;
            cp_valid_reg  <= cp_valid_next;
            read_hit_reg  <= read_hit_next;
            m_valid_reg   <= m_valid_next;
        end
        src_reg    <= src_next;
        cp_dst_reg <= cp_dst_next;
        m_data_reg <= m_data_next;
    end

    // Screen store ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= screen_mem[mem_raddr];
    end

endmodule

// ===== hdl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: front end, command queue, executor.
// Depends on tcce_pkg, tcce_front, tcce_fifo and tcce_exec.
//
//   Channel   Ports                         Direction  Beat
//   input     s_valid / s_ready / s_data    in         item_t: op, char_code, cell_addr
//   result    m_valid / m_ready / m_data    out        res_t: one per input beat
//   config    cfg_wr_en / cfg_wr_data       in         text attribute byte, no wait
//
// Put, backspace, mark start, read and a non-scrolling new line pass S_IDLE and S_EMIT;
// no new command is taken until the executor is back in S_IDLE. A beat passes the
// front-end register and the queue to the executor. A clear blanks every cell; a scroll
// copies each cell up one row, then blanks the last row, one cell per cycle through the
// single write port. After reset the store is blanked with s_ready low. The queue lets
// the front end keep taking beats while the executor or results stall.
module text_console_cursor_engine import tcce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  item_t             s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output res_t              m_data
);

    logic init_done;
    logic fe_valid, fe_ready;
    cmd_t fe_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;

    // Classify incoming beats.
    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd_data  (fe_cmd)
    );

    // Decouple the front end from the executor.
    tcce_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_cmd)
    );

    // Carry out commands against the screen store.
    tcce_exec #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd_data    (q_cmd),
        .init_done   (init_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Reset always starts the blanking sweep, so no beat is taken just after it.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input accepted straight after reset");

    // A command leaves the queue only when the result register can take its result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> (!m_valid || m_ready))
        else $error("command taken while the result register is blocked");

    // The reported cursor column never runs past the last column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    // No beat is taken from the queue while the store is being blanked after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !(q_valid && q_ready))
        else $error("command taken during the reset sweep");

endmodule
